### rtl/assert_macros.svh
// assertion macros for the modbus response checker
// expects i_clk and i_rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define MBRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define MBRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/mbrc_pkg.sv
// shared types and constants for the modbus read response checker
// no dependencies
package mbrc_pkg;

    localparam int DEFAULT_MAX_REGISTERS = 16;

    localparam int BYTE_W   = 8;
    localparam int CRC_W    = 16;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;
    // highest position is 3 + 2 * 31 + 1
    localparam int POS_W    = 7;

    localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'hA001;
    localparam logic [BYTE_W-1:0] FUNC_READ = 8'h03;

    localparam logic [BYTE_W-1:0]  SLAVE_RESET = 8'd1;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd2;

    // configuration register indexes
    localparam logic CFG_SLAVE = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SLAVE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FUNC    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_COUNT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CRC     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd5;

    typedef struct packed {
        logic              init;   // load the crc seed
        logic              start;  // fold in a byte, then eight shift steps
        logic [BYTE_W-1:0] data;
    } t_crc_ctrl;

endpackage

### rtl/modbus_read_response_checker.sv
// Modbus RTU read-holding-registers response checker. Each received byte is
// taken in one transfer; header and data bytes then run through a bit-serial
// crc unit (eight shift steps, then the return to idle), while the crc low
// byte is only stored. On the final crc byte a good frame delivers one
// result per register of register_count (clamped to 1 .. MAX_REGISTERS,
// at most 31), each by a store read and then an output register load; a
// failed frame or a deadline delivers one status item. The input side stalls
// from a byte's transfer until its crc steps or its results are all loaded
// into the output register; the output register lets the next byte arrive
// while the last result still waits. No clearing pass after reset.
// depends on mbrc_pkg, mbrc_crc_unit, mbrc_reg_store, assert_macros.svh
`include "assert_macros.svh"

module modbus_read_response_checker #(
    parameter int MAX_REGISTERS = mbrc_pkg::DEFAULT_MAX_REGISTERS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [mbrc_pkg::BYTE_W-1:0]     i_cfg_data,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_func,
    input  logic [mbrc_pkg::BYTE_W-1:0]     i_data_byte,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [mbrc_pkg::STATUS_W-1:0]   o_status,
    output logic [mbrc_pkg::INDEX_W-1:0]    o_reg_index,
    output logic [mbrc_pkg::CRC_W-1:0]      o_reg_value,
    output logic                            o_last
);
    import mbrc_pkg::*;

    localparam int ADDR_W = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;
    localparam int MAX_N  = (MAX_REGISTERS > 31) ? 31 : MAX_REGISTERS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CRC  = 5'b00010,
        S_ERR  = 5'b00100,
        S_RD   = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [BYTE_W-1:0]    r_slave;
    logic [COUNT_W-1:0]   r_count;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [STATUS_W-1:0]  r_err, n_err;
    logic [BYTE_W-1:0]    r_pending, n_pending;
    logic [BYTE_W-1:0]    r_crc_lo, n_crc_lo;
    logic [STATUS_W-1:0]  r_code, n_code;
    logic [COUNT_W-1:0]   r_n, n_n;
    logic [COUNT_W-1:0]   r_idx, n_idx;

    logic                 r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]  r_out_status, n_out_status;
    logic [INDEX_W-1:0]   r_out_index, n_out_index;
    logic [CRC_W-1:0]     r_out_value, n_out_value;
    logic                 r_out_last, n_out_last;

    t_crc_ctrl            crc_ctrl;
    logic [CRC_W-1:0]     crc_value;
    logic                 crc_busy;

    logic                 mem_we, mem_re;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [CRC_W-1:0]     mem_rdata;

    logic                 in_acc, out_free, is_last;
    logic [COUNT_W-1:0]   n_eff;
    logic [POS_W-1:0]     crc_pos, offset;
    logic [POS_W-1:0]     word_idx;

    mbrc_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (crc_ctrl),
        .o_crc   (crc_value),
        .o_busy  (crc_busy)
    );

    mbrc_reg_store #(
        .DEPTH  (MAX_REGISTERS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata ({r_pending, i_data_byte}),
        .i_re    (mem_re),
        .i_raddr (ADDR_W'(r_idx)),
        .o_rdata (mem_rdata)
    );

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // clamp the register count to 1 .. MAX_REGISTERS, and to at most 31
    always_comb begin
        if (r_count == '0) begin
            n_eff = COUNT_W'(1);
        end else if (r_count > COUNT_W'(MAX_N)) begin
            n_eff = COUNT_W'(MAX_N);
        end else begin
            n_eff = r_count;
        end
    end

    assign crc_pos   = POS_W'({n_eff, 1'b0}) + POS_W'(3);
    assign offset    = r_pos - POS_W'(3);
    assign word_idx  = offset >> 1;
    assign mem_waddr = ADDR_W'(word_idx);
    assign is_last   = ((r_idx + COUNT_W'(1)) == r_n);

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_err        = r_err;
        n_pending    = r_pending;
        n_crc_lo     = r_crc_lo;
        n_code       = r_code;
        n_n          = r_n;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        crc_ctrl     = '0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_func || (r_pos > crc_pos)) begin
                        // frame ends here: restart frame state
                        n_pos         = '0;
                        n_err         = ST_OK;
                        n_pending     = '0;
                        n_crc_lo      = '0;
                        crc_ctrl.init = 1'b1;
                        if (i_func) begin
                            n_code  = ST_TIMEOUT;
                            n_state = S_ERR;
                        end else if (r_err != ST_OK) begin
                            n_code  = r_err;
                            n_state = S_ERR;
                        end else if (crc_value != {i_data_byte, r_crc_lo}) begin
                            n_code  = ST_CRC;
                            n_state = S_ERR;
                        end else begin
                            n_n     = n_eff;
                            n_idx   = '0;
                            n_state = S_RD;
                        end
                    end else if (r_pos == crc_pos) begin
                        n_crc_lo = i_data_byte;
                        n_pos    = r_pos + POS_W'(1);
                    end else begin
                        crc_ctrl.start = 1'b1;
                        crc_ctrl.data  = i_data_byte;
                        n_pos          = r_pos + POS_W'(1);
                        n_state        = S_CRC;
                        if (r_pos == POS_W'(0)) begin
                            if (i_data_byte != r_slave && r_err == ST_OK) begin
                                n_err = ST_SLAVE;
                            end
                        end else if (r_pos == POS_W'(1)) begin
                            if (i_data_byte != FUNC_READ && r_err == ST_OK) begin
                                n_err = ST_FUNC;
                            end
                        end else if (r_pos == POS_W'(2)) begin
                            if (i_data_byte != BYTE_W'({n_eff, 1'b0}) && r_err == ST_OK) begin
                                n_err = ST_COUNT;
                            end
                        end else if (!offset[0]) begin
                            n_pending = i_data_byte;
                        end else if (int'(word_idx) < MAX_REGISTERS) begin
                            mem_we = 1'b1;
                        end
                    end
                end
            end
            S_CRC: begin
                if (!crc_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_code;
                    n_out_index  = '0;
                    n_out_value  = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RD: begin
                mem_re  = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_index  = INDEX_W'(r_idx);
                    n_out_value  = mem_rdata;
                    n_out_last   = is_last;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + COUNT_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slave     <= SLAVE_RESET;
            r_count     <= COUNT_RESET;
            r_pos       <= '0;
            r_err       <= ST_OK;
            r_pending   <= '0;
            r_crc_lo    <= '0;
            r_code      <= ST_OK;
            r_n         <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_err       <= n_err;
            r_pending   <= n_pending;
            r_crc_lo    <= n_crc_lo;
            r_code      <= n_code;
            r_n         <= n_n;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SLAVE: r_slave <= i_cfg_data;
                    CFG_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                    default:   r_slave <= r_slave;
                endcase
            end
        end
    end

    // output payload, held while stalled
    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_reg_index = r_out_index;
    assign o_reg_value = r_out_value;
    assign o_last      = r_out_last;

    `MBRC_ASSERT_NOW(a_err_item_clean, o_out_valid && o_status != ST_OK, o_reg_index == '0 && o_reg_value == '0 && o_last)
    `MBRC_ASSERT_NOW(a_no_accept_busy_crc, in_acc, !crc_busy)
    `MBRC_ASSERT_NEXT(a_deadline_restart, in_acc && i_func, r_pos == '0 && r_err == ST_OK && r_state == S_ERR)

endmodule

### rtl/mbrc_crc_unit.sv
// bit-serial crc-16/modbus unit, one shift/xor step per cycle
// depends on mbrc_pkg
module mbrc_crc_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mbrc_pkg::t_crc_ctrl            i_ctrl,
    output logic [mbrc_pkg::CRC_W-1:0]     o_crc,
    output logic                           o_busy
);
    import mbrc_pkg::*;

    logic [CRC_W-1:0] r_crc, n_crc;
    logic [3:0]       r_steps, n_steps;

    always_comb begin
        n_crc   = r_crc;
        n_steps = r_steps;
        if (i_ctrl.init) begin
            n_crc   = CRC_INIT;
            n_steps = 4'd0;
        end else if (i_ctrl.start) begin
            n_crc   = r_crc ^ {{(CRC_W-BYTE_W){1'b0}}, i_ctrl.data};
            n_steps = 4'd8;
        end else if (r_steps != 4'd0) begin
            n_crc   = r_crc[0] ? ((r_crc >> 1) ^ CRC_POLY) : (r_crc >> 1);
            n_steps = r_steps - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= CRC_INIT;
            r_steps <= 4'd0;
        end else begin
            r_crc   <= n_crc;
            r_steps <= n_steps;
        end
    end

    assign o_crc  = r_crc;
    assign o_busy = (r_steps != 4'd0);

endmodule

### rtl/mbrc_reg_store.sv
// register word store, one write and one registered read per cycle
// depends on mbrc_pkg
module mbrc_reg_store #(
    parameter int DEPTH  = mbrc_pkg::DEFAULT_MAX_REGISTERS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [mbrc_pkg::CRC_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [ADDR_W-1:0]          i_raddr,
    output logic [mbrc_pkg::CRC_W-1:0] o_rdata
);
    import mbrc_pkg::*;

    logic [CRC_W-1:0] r_mem [DEPTH];
    logic [CRC_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
